>>> design/jvam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jvam_pkg
// Shared types and constants of the joystick virtual axis mixer.
// ----------------------------------------------------------------------------
package jvam_pkg;

    // default sizes handed down from the top level
    localparam int DEF_AXIS_COUNT         = 8;
    localparam int DEF_BUTTON_COUNT       = 16;
    localparam int DEF_VIRTUAL_AXIS_COUNT = 8;
    localparam int DEF_TABLE_DEPTH        = 16;

    // number of virtual axis slots on the result stream
    localparam int VOUT = 8;

    // stream payload widths
    localparam int FUNC_W = 2;
    localparam int IN_W   = 120;
    localparam int OUT_W  = VOUT * 32 + 48;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODEL_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SIZE   = 2'd1;

    // func codes
    localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPLY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

    // event type codes, init flag stripped
    localparam logic [6:0] EVT_BUTTON = 7'd1;
    localparam logic [6:0] EVT_AXIS   = 7'd2;

    // table entry words
    // select: [0] is_button, [4:1] source, [19:5] dead zone,
    //         [27:20] target, [43:28] button mask
    // gain:   [15:0] weight, [39:16] bias
    localparam int SEL_W  = 44;
    localparam int GAIN_W = 40;

    // 1.0 in Q1.15, one bit wider than the raw axis
    localparam logic [16:0] ONE_Q15 = 17'h08000;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [1:0] {
        CMD_AXIS,
        CMD_BUTTON,
        CMD_WRITE,
        CMD_APPLY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         num;     // axis, button or slot number
        logic [15:0]        value;   // axis position, bit 0 = button pressed
        logic [SEL_W-1:0]   sel;
        logic [GAIN_W-1:0]  gain;
    } cmd_t;

endpackage
`default_nettype wire

>>> design/jvam_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jvam_front
// Input side: unpacks items, drops those without effect, builds commands.
// ----------------------------------------------------------------------------
module jvam_front #(
    parameter int AXIS_COUNT   = jvam_pkg::DEF_AXIS_COUNT,
    parameter int BUTTON_COUNT = jvam_pkg::DEF_BUTTON_COUNT,
    parameter int TABLE_DEPTH  = jvam_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [jvam_pkg::IN_W-1:0]   s_tdata,
    input  wire logic [jvam_pkg::FUNC_W-1:0] s_tuser,
    input  wire logic                        q_full,
    output logic                             q_push,
    output jvam_pkg::cmd_t                   q_cmd
);

    logic [6:0]  evt_type;
    logic [7:0]  evt_num;
    logic [15:0] evt_value;
    logic [3:0]  slot;
    logic        keep;

    assign evt_type  = s_tdata[6:0];    // bit 7 (init) ignored
    assign evt_num   = s_tdata[15:8];
    assign evt_value = s_tdata[31:16];
    assign slot      = s_tdata[35:32];

    always_comb
    begin
        q_cmd.kind  = jvam_pkg::CMD_APPLY;
        q_cmd.num   = evt_num;
        q_cmd.value = evt_value;
        // mask, target, dead zone, source, is_button
        q_cmd.sel   = {s_tdata[119:104], s_tdata[103:96], s_tdata[55:41],
                       s_tdata[40:37], s_tdata[36]};
        // bias, weight
        q_cmd.gain  = {s_tdata[95:72], s_tdata[71:56]};
        keep        = 1'b0;
        unique case (s_tuser)
            jvam_pkg::FUNC_EVENT:
            begin
                if (evt_type == jvam_pkg::EVT_AXIS)
                begin
                    q_cmd.kind = jvam_pkg::CMD_AXIS;
                    keep       = (evt_num < 8'(AXIS_COUNT));
                end
                else if (evt_type == jvam_pkg::EVT_BUTTON)
                begin
                    q_cmd.kind  = jvam_pkg::CMD_BUTTON;
                    q_cmd.value = {15'd0, ~evt_value[15] && (evt_value != 16'd0)};
                    keep        = (evt_num < 8'(BUTTON_COUNT));
                end
            end
            jvam_pkg::FUNC_APPLY:
            begin
                q_cmd.kind = jvam_pkg::CMD_APPLY;
                keep       = 1'b1;
            end
            jvam_pkg::FUNC_WRITE:
            begin
                q_cmd.kind = jvam_pkg::CMD_WRITE;
                q_cmd.num  = {4'd0, slot};
                keep       = ({1'b0, slot} < 5'(TABLE_DEPTH));
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = ~q_full;
    assign q_push   = s_tvalid && ~q_full && keep;

endmodule
`default_nettype wire

>>> design/jvam_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jvam_queue
// Short command FIFO between the input side and the execution side.
// ----------------------------------------------------------------------------
module jvam_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire jvam_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output jvam_pkg::cmd_t      head
);

    jvam_pkg::cmd_t               fifo_mem [jvam_pkg::QUEUE_DEPTH];
    logic [jvam_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [jvam_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [jvam_pkg::QPTR_W:0]    count_reg;
    logic                         do_pop;

    assign full   = (count_reg == (jvam_pkg::QPTR_W + 1)'(jvam_pkg::QUEUE_DEPTH));
    assign valid  = (count_reg != '0);
    assign head   = fifo_mem[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/jvam_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jvam_back
// Execution side: axis/button stores, mixing table, multiply-accumulate walk
// over the table on apply, and the result register.
// ----------------------------------------------------------------------------
module jvam_back #(
    parameter int AXIS_COUNT         = jvam_pkg::DEF_AXIS_COUNT,
    parameter int BUTTON_COUNT       = jvam_pkg::DEF_BUTTON_COUNT,
    parameter int VIRTUAL_AXIS_COUNT = jvam_pkg::DEF_VIRTUAL_AXIS_COUNT,
    parameter int TABLE_DEPTH        = jvam_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             q_valid,
    input  wire jvam_pkg::cmd_t                   q_cmd,
    output logic                                  q_pop,
    input  wire logic                             cfg_valid,
    input  wire logic [jvam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [jvam_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [jvam_pkg::OUT_W-1:0]            m_tdata
);

    localparam int AX_IDX_W  = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam int BTN_IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int VA_IDX_W  = (VIRTUAL_AXIS_COUNT > 1) ? $clog2(VIRTUAL_AXIS_COUNT) : 1;
    localparam int TBL_IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_MUL,
        S_ACC,
        S_FINISH,
        S_EMIT
    } state_t;

    state_t                           state_reg;
    logic                             enable_reg;
    logic [4:0]                       size_reg;
    logic [4:0]                       cnt_reg;
    logic [4:0]                       lim_reg;
    logic [4:0]                       lim_next;

    logic [15:0]                      axis_reg [AXIS_COUNT];
    logic [BUTTON_COUNT-1:0]          button_reg;
    logic [31:0]                      va_reg [VIRTUAL_AXIS_COUNT];
    logic [15:0]                      hold_mask_reg;
    logic [15:0]                      press_mask_reg;
    logic [15:0]                      release_mask_reg;
    logic [15:0]                      hold_acc_reg;

    logic [jvam_pkg::SEL_W-1:0]       sel_mem [TABLE_DEPTH];
    logic [jvam_pkg::GAIN_W-1:0]      gain_mem [TABLE_DEPTH];
    logic [jvam_pkg::SEL_W-1:0]       sel_rd_reg;
    logic [jvam_pkg::GAIN_W-1:0]      gain_rd_reg;
    logic                             tbl_we;

    logic signed [16:0]               v_reg;
    logic signed [15:0]               weight_reg;
    logic [23:0]                      bias_reg;
    logic [7:0]                       tgt_reg;
    logic signed [32:0]               prod_reg;

    logic                             m_tvalid_reg;
    logic [jvam_pkg::OUT_W-1:0]       m_tdata_reg;

    // entry evaluation
    logic                             e_is_btn;
    logic [3:0]                       e_src;
    logic [14:0]                      e_dz;
    logic [15:0]                      e_bmask;
    logic [15:0]                      e_ax;
    logic [16:0]                      e_ax17;
    logic [16:0]                      e_mag;
    logic [16:0]                      e_dz17;
    logic [16:0]                      e_v_axis;
    logic                             e_btn_on;
    logic [16:0]                      e_v;

    // accumulate
    logic [21:0]                      a_shift;
    logic [24:0]                      a_add;
    logic [31:0]                      a_cur;
    logic [32:0]                      a_sum;
    logic [31:0]                      a_sat;
    logic                             a_tgt_ok;

    logic [jvam_pkg::OUT_W-1:0]       out_data;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign tbl_we   = q_pop && (q_cmd.kind == jvam_pkg::CMD_WRITE);
    assign lim_next = (size_reg > 5'(TABLE_DEPTH)) ? 5'(TABLE_DEPTH) : size_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        e_is_btn = sel_rd_reg[0];
        e_src    = sel_rd_reg[4:1];
        e_dz     = sel_rd_reg[19:5];
        e_bmask  = sel_rd_reg[43:28];
        e_ax     = ({4'd0, e_src} < 8'(AXIS_COUNT)) ? axis_reg[e_src[AX_IDX_W-1:0]] : 16'd0;
        e_btn_on = ({4'd0, e_src} < 8'(BUTTON_COUNT)) && button_reg[e_src[BTN_IDX_W-1:0]];
        e_ax17   = {e_ax[15], e_ax};
        e_mag    = e_ax[15] ? (17'd0 - e_ax17) : e_ax17;
        e_dz17   = {2'd0, e_dz};
        // strict dead zone, then shrink toward zero
        if (e_mag > e_dz17)
        begin
            e_v_axis = e_ax[15] ? (e_ax17 + e_dz17) : (e_ax17 - e_dz17);
        end
        else
        begin
            e_v_axis = 17'd0;
        end
        if (e_is_btn)
        begin
            e_v = e_btn_on ? jvam_pkg::ONE_Q15 : 17'd0;
        end
        else
        begin
            e_v = e_v_axis;
        end
    end

    always_comb
    begin
        // floor shift of the Q.27 product down to Q.16
        a_shift  = prod_reg[32:11];
        a_add    = {{3{a_shift[21]}}, a_shift} + {bias_reg[23], bias_reg};
        a_cur    = va_reg[tgt_reg[VA_IDX_W-1:0]];
        a_sum    = {a_cur[31], a_cur} + {{8{a_add[24]}}, a_add};
        a_tgt_ok = (tgt_reg < 8'(VIRTUAL_AXIS_COUNT));
        if (a_sum[32] != a_sum[31])
        begin
            a_sat = a_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            a_sat = a_sum[31:0];
        end
    end

    always_comb
    begin
        out_data = '0;
        for (int j = 0; j < jvam_pkg::VOUT; j++)
        begin
            if (j < VIRTUAL_AXIS_COUNT)
            begin
                out_data[j*32 +: 32] = va_reg[j];
            end
        end
        out_data[jvam_pkg::VOUT*32      +: 16] = hold_mask_reg;
        out_data[jvam_pkg::VOUT*32 + 16 +: 16] = press_mask_reg;
        out_data[jvam_pkg::VOUT*32 + 32 +: 16] = release_mask_reg;
    end

    // mixing table
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            sel_mem[q_cmd.num[TBL_IDX_W-1:0]]  <= q_cmd.sel;
            gain_mem[q_cmd.num[TBL_IDX_W-1:0]] <= q_cmd.gain;
        end
        sel_rd_reg  <= sel_mem[cnt_reg[TBL_IDX_W-1:0]];
        gain_rd_reg <= gain_mem[cnt_reg[TBL_IDX_W-1:0]];
    end

    // datapath registers of the walk
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EVAL)
        begin
            v_reg      <= e_v;
            weight_reg <= gain_rd_reg[15:0];
            bias_reg   <= gain_rd_reg[39:16];
            tgt_reg    <= sel_rd_reg[27:20];
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= v_reg * weight_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            enable_reg       <= 1'b0;
            size_reg         <= '0;
            cnt_reg          <= '0;
            lim_reg          <= '0;
            button_reg       <= '0;
            hold_mask_reg    <= '0;
            press_mask_reg   <= '0;
            release_mask_reg <= '0;
            hold_acc_reg     <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                axis_reg[i] <= '0;
            end
            for (int i = 0; i < VIRTUAL_AXIS_COUNT; i++)
            begin
                va_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == jvam_pkg::CFG_MODEL_ENABLE)
                begin
                    enable_reg <= cfg_data[0];
                end
                else if (cfg_index == jvam_pkg::CFG_TABLE_SIZE)
                begin
                    size_reg <= cfg_data;
                end
            end

            // the emit state handles the valid flag itself
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        unique case (q_cmd.kind)
                            jvam_pkg::CMD_AXIS:
                            begin
                                axis_reg[q_cmd.num[AX_IDX_W-1:0]] <= q_cmd.value;
                            end
                            jvam_pkg::CMD_BUTTON:
                            begin
                                button_reg[q_cmd.num[BTN_IDX_W-1:0]] <= q_cmd.value[0];
                            end
                            jvam_pkg::CMD_WRITE:
                            begin
                                // table write done in the memory block
                            end
                            jvam_pkg::CMD_APPLY:
                            begin
                                if (enable_reg)
                                begin
                                    for (int i = 0; i < VIRTUAL_AXIS_COUNT; i++)
                                    begin
                                        va_reg[i] <= '0;
                                    end
                                    hold_acc_reg <= '0;
                                    cnt_reg      <= '0;
                                    lim_reg      <= lim_next;
                                    state_reg    <= (lim_next == 5'd0) ? S_FINISH : S_READ;
                                end
                                else
                                begin
                                    state_reg <= S_EMIT;
                                end
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (e_is_btn && e_btn_on)
                    begin
                        hold_acc_reg <= hold_acc_reg | e_bmask;
                    end
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (a_tgt_ok)
                    begin
                        va_reg[tgt_reg[VA_IDX_W-1:0]] <= a_sat;
                    end
                    cnt_reg   <= cnt_reg + 5'd1;
                    state_reg <= ((cnt_reg + 5'd1) == lim_reg) ? S_FINISH : S_READ;
                end
                S_FINISH:
                begin
                    hold_mask_reg    <= hold_acc_reg;
                    press_mask_reg   <= hold_acc_reg & ~hold_mask_reg;
                    release_mask_reg <= hold_mask_reg & ~hold_acc_reg;
                    state_reg        <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= out_data;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (cnt_reg < lim_reg))
        else $error("table walk index past model size");

    a_press_release_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (press_mask_reg & release_mask_reg) == 16'd0)
        else $error("button both pressed and released");

    a_press_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (press_mask_reg & ~hold_mask_reg) == 16'd0)
        else $error("pressed button not held");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

endmodule
`default_nettype wire

>>> design/joystick_virtual_axis_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_virtual_axis_mixer
// Joystick event store and virtual axis mixer with dead zones.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one item per transaction, func in s_tuser. Joystick events
//   and table writes give no result; an apply gives one transaction on m_*
//   with the eight virtual axes and the hold, press and release masks.
//   cfg_* writes model_enable (index 0) and the table size (index 1); it is
//   always ready and must only be used while the block is idle.
// Flow:
//   Items are classified on entry and placed in a 4-deep command queue.
//   An event or table write executes as it is popped from the queue. An
//   apply walks N = min(table size, TABLE_DEPTH) table entries through the
//   shared multiply-accumulate unit, one entry at a time (table read,
//   evaluate, multiply, add), then updates the masks and emits the result;
//   with the model disabled it skips the walk and emits the stored values.
// Reset:
//   Axis, button and virtual axis stores and masks clear; table contents
//   are undefined until written.
// Backpressure:
//   The result register holds while m_tready is low; the execution side
//   waits, the queue fills and s_tready drops when it is full.
// ----------------------------------------------------------------------------
module joystick_virtual_axis_mixer #(
    parameter int AXIS_COUNT         = jvam_pkg::DEF_AXIS_COUNT,
    parameter int BUTTON_COUNT       = jvam_pkg::DEF_BUTTON_COUNT,
    parameter int VIRTUAL_AXIS_COUNT = jvam_pkg::DEF_VIRTUAL_AXIS_COUNT,
    parameter int TABLE_DEPTH        = jvam_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // event_type, event_number, event_value, entry_slot, entry_is_button,
    // entry_source, entry_dead_zone, entry_weight, entry_bias,
    // entry_target, entry_button_mask
    input  wire logic [jvam_pkg::IN_W-1:0]        s_tdata,
    // func
    input  wire logic [jvam_pkg::FUNC_W-1:0]      s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // virtual_axis_0 .. virtual_axis_7, hold_bits, press_bits, release_bits
    output logic [jvam_pkg::OUT_W-1:0]            m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [jvam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [jvam_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic           q_full;
    logic           q_push;
    jvam_pkg::cmd_t q_push_cmd;
    logic           q_valid;
    logic           q_pop;
    jvam_pkg::cmd_t q_head;

    assign cfg_ready = 1'b1;

    jvam_front #(
        .AXIS_COUNT   (AXIS_COUNT),
        .BUTTON_COUNT (BUTTON_COUNT),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    jvam_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    jvam_back #(
        .AXIS_COUNT         (AXIS_COUNT),
        .BUTTON_COUNT       (BUTTON_COUNT),
        .VIRTUAL_AXIS_COUNT (VIRTUAL_AXIS_COUNT),
        .TABLE_DEPTH        (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire
